// File: rtl/nnpds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package nnpds_pkg;

   localparam int ADDR_W    = 32;
   localparam int BYTE_W    = 8;
   localparam int CFG_W     = 16;
   localparam int BPP_W     = 3;
   localparam int COMP_W    = 2;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SOURCE_WIDTH    = 3'd0,
      CSR_SOURCE_HEIGHT   = 3'd1,
      CSR_BYTES_PER_PIXEL = 3'd2,
      CSR_POW2_MODE       = 3'd3,
      CSR_TARGET_WIDTH    = 3'd4,
      CSR_TARGET_HEIGHT   = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_MUL,
      ST_SUM,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic accept;
      logic mul_en;
      logic sum_en;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic item_ok;
      logic div_done;
      logic out_free;
   } status_type;

   // highest set bit, or one for a zero size
   function automatic logic [CFG_W-1:0] pow2_floor(input logic [CFG_W-1:0] v);
      logic [CFG_W-1:0] result;
      result = CFG_W'(1);
      for (int i = 0; i < CFG_W; i++) begin
         if (v[i]) begin
            result = CFG_W'(1) << i;
         end
      end
      return result;
   endfunction

endpackage
`default_nettype wire

// File: rtl/nnpds_div.sv
`timescale 1ns / 1ps
`default_nettype none
module nnpds_div #(
   parameter int DIM_BITS = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic [2*DIM_BITS-1:0]   dividend,
   input  wire logic [DIM_BITS-1:0]     divisor,
   output logic      [2*DIM_BITS-1:0]   quotient,
   output logic                         done
);

   localparam int Q_W   = 2 * DIM_BITS;
   localparam int CNT_W = $clog2(Q_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [Q_W-1:0]    q_ff, q_in;
   logic [DIM_BITS-1:0] rem_ff, rem_in;
   logic [DIM_BITS-1:0] dvs_ff, dvs_in;
   logic [DIM_BITS:0]   rem_sh;
   logic [DIM_BITS:0]   rem_diff;

   assign rem_sh   = {rem_ff, q_ff[Q_W-1]};
   assign rem_diff = rem_sh - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         q_in    = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, dvs_ff}) begin
            rem_in = rem_diff[DIM_BITS-1:0];
            q_in   = {q_ff[Q_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DIM_BITS-1:0];
            q_in   = {q_ff[Q_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(Q_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = q_ff;
   assign done     = done_ff;

endmodule
`default_nettype wire

// File: rtl/nnpds_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module nnpds_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire nnpds_pkg::status_type  status,
   output nnpds_pkg::cmd_type          cmd,
   output logic                        req_stall
);

   nnpds_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         nnpds_pkg::ST_IDLE: begin
            if (req_valid && status.item_ok) begin
               state_in = nnpds_pkg::ST_DIV;
            end
         end
         nnpds_pkg::ST_DIV: begin
            if (status.div_done) begin
               state_in = nnpds_pkg::ST_MUL;
            end
         end
         nnpds_pkg::ST_MUL: begin
            state_in = nnpds_pkg::ST_SUM;
         end
         nnpds_pkg::ST_SUM: begin
            state_in = nnpds_pkg::ST_OUT;
         end
         nnpds_pkg::ST_OUT: begin
            if (status.out_free) begin
               state_in = nnpds_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = nnpds_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         nnpds_pkg::ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         nnpds_pkg::ST_MUL: begin
            cmd.mul_en = 1'b1;
         end
         nnpds_pkg::ST_SUM: begin
            cmd.sum_en = 1'b1;
         end
         nnpds_pkg::ST_OUT: begin
            cmd.out_load = status.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nnpds_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/nnpds_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
module nnpds_dpath #(
   parameter int DIM_BITS       = 16,
   parameter int MAX_COMPONENTS = 4
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_enable,
   input  wire logic [nnpds_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [nnpds_pkg::CFG_W-1:0]         csr_write_data,
   input  wire logic [nnpds_pkg::BYTE_W-1:0]        req_source_byte,
   input  wire logic                                rsp_stall,
   input  wire nnpds_pkg::cmd_type                  cmd,
   output nnpds_pkg::status_type                    status,
   output logic                                     rsp_valid,
   output logic [nnpds_pkg::ADDR_W-1:0]             rsp_dest_address,
   output logic [nnpds_pkg::BYTE_W-1:0]             rsp_dest_byte,
   output logic                                     rsp_frame_last
);

   localparam int PROD_W = 2 * DIM_BITS;
   localparam int AW     = nnpds_pkg::ADDR_W;
   localparam int CW     = nnpds_pkg::COMP_W;
   localparam int BW     = nnpds_pkg::BPP_W;

   // configuration
   logic [nnpds_pkg::CFG_W-1:0] src_w_ff, src_h_ff, tgt_w_ff, tgt_h_ff;
   logic [BW-1:0]               bpp_ff;
   logic                        pow2_ff;

   // position and latched target
   logic [DIM_BITS-1:0] col_cnt_ff, col_cnt_in;
   logic [DIM_BITS-1:0] row_cnt_ff, row_cnt_in;
   logic [CW-1:0]       comp_cnt_ff, comp_cnt_in;
   logic [DIM_BITS-1:0] dw_ff, dw_in;
   logic [DIM_BITS-1:0] dh_ff, dh_in;

   // captured request
   logic [nnpds_pkg::BYTE_W-1:0] byte_ff;
   logic [CW-1:0]                comp_cap_ff;
   logic [BW-1:0]                bpp_cap_ff;
   logic                         last_cap_ff;

   logic [AW-1:0] prod_ff;
   logic [AW-1:0] sum_ff;

   logic                         rsp_valid_ff;
   logic [AW-1:0]                rsp_addr_ff;
   logic [nnpds_pkg::BYTE_W-1:0] rsp_byte_ff;
   logic                         rsp_last_ff;

   logic [DIM_BITS-1:0] sw, sh, dw_sel, dh_sel, dw_next, dh_next;
   logic [nnpds_pkg::CFG_W-1:0] sw_p2, sh_p2;
   logic                fmt_ok, size_ok, tgt_ok, item_ok, frame_start;
   logic                last_comp, last_col, last_row, go;
   logic [PROD_W-1:0]   col_dividend, row_dividend;
   logic [PROD_W-1:0]   col_q, row_q;
   logic                col_done, row_done;
   logic [AW-1:0]       row_mul;
   logic                out_free;

   assign sw    = src_w_ff[DIM_BITS-1:0];
   assign sh    = src_h_ff[DIM_BITS-1:0];
   assign sw_p2 = nnpds_pkg::pow2_floor(nnpds_pkg::CFG_W'(sw));
   assign sh_p2 = nnpds_pkg::pow2_floor(nnpds_pkg::CFG_W'(sh));

   assign dw_sel = pow2_ff ? sw_p2[DIM_BITS-1:0] : tgt_w_ff[DIM_BITS-1:0];
   assign dh_sel = pow2_ff ? sh_p2[DIM_BITS-1:0] : tgt_h_ff[DIM_BITS-1:0];

   assign frame_start = (col_cnt_ff == '0) && (row_cnt_ff == '0) && (comp_cnt_ff == '0);
   assign dw_next     = frame_start ? dw_sel : dw_ff;
   assign dh_next     = frame_start ? dh_sel : dh_ff;

   assign fmt_ok  = (bpp_ff != '0) && (bpp_ff <= BW'(MAX_COMPONENTS));
   assign size_ok = (sw != '0) && (sh != '0);
   assign tgt_ok  = (dw_next != '0) && (dh_next != '0);
   assign item_ok = fmt_ok && size_ok && tgt_ok;
   assign go      = cmd.accept && item_ok;

   assign last_comp = ({1'b0, comp_cnt_ff} + BW'(1)) >= bpp_ff;
   assign last_col  = ({1'b0, col_cnt_ff} + (DIM_BITS + 1)'(1)) >= {1'b0, sw};
   assign last_row  = ({1'b0, row_cnt_ff} + (DIM_BITS + 1)'(1)) >= {1'b0, sh};

   assign col_dividend = PROD_W'(dw_next) * PROD_W'(col_cnt_ff);
   assign row_dividend = PROD_W'(dh_next) * PROD_W'(row_cnt_ff);

   nnpds_div #(.DIM_BITS(DIM_BITS)) u_col_div (
      .clock    (clock),
      .reset    (reset),
      .start    (go),
      .dividend (col_dividend),
      .divisor  (sw),
      .quotient (col_q),
      .done     (col_done)
   );

   nnpds_div #(.DIM_BITS(DIM_BITS)) u_row_div (
      .clock    (clock),
      .reset    (reset),
      .start    (go),
      .dividend (row_dividend),
      .divisor  (sh),
      .quotient (row_q),
      .done     (row_done)
   );

   assign row_mul = AW'(row_q) * AW'(dw_ff);

   always_comb begin
      col_cnt_in  = col_cnt_ff;
      row_cnt_in  = row_cnt_ff;
      comp_cnt_in = comp_cnt_ff;
      dw_in       = dw_ff;
      dh_in       = dh_ff;
      if (cmd.accept && fmt_ok && size_ok && frame_start) begin
         dw_in = dw_sel;
         dh_in = dh_sel;
      end
      if (go) begin
         if (!last_comp) begin
            comp_cnt_in = comp_cnt_ff + CW'(1);
         end else begin
            comp_cnt_in = '0;
            if (!last_col) begin
               col_cnt_in = col_cnt_ff + DIM_BITS'(1);
            end else begin
               col_cnt_in = '0;
               if (!last_row) begin
                  row_cnt_in = row_cnt_ff + DIM_BITS'(1);
               end else begin
                  row_cnt_in = '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= '0;
         src_h_ff <= '0;
         bpp_ff   <= '0;
         pow2_ff  <= 1'b1;
         tgt_w_ff <= '0;
         tgt_h_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            nnpds_pkg::CSR_SOURCE_WIDTH:    src_w_ff <= csr_write_data;
            nnpds_pkg::CSR_SOURCE_HEIGHT:   src_h_ff <= csr_write_data;
            nnpds_pkg::CSR_BYTES_PER_PIXEL: bpp_ff   <= csr_write_data[BW-1:0];
            nnpds_pkg::CSR_POW2_MODE:       pow2_ff  <= csr_write_data[0];
            nnpds_pkg::CSR_TARGET_WIDTH:    tgt_w_ff <= csr_write_data;
            nnpds_pkg::CSR_TARGET_HEIGHT:   tgt_h_ff <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff  <= '0;
         row_cnt_ff  <= '0;
         comp_cnt_ff <= '0;
         dw_ff       <= '0;
         dh_ff       <= '0;
      end else begin
         col_cnt_ff  <= col_cnt_in;
         row_cnt_ff  <= row_cnt_in;
         comp_cnt_ff <= comp_cnt_in;
         dw_ff       <= dw_in;
         dh_ff       <= dh_in;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         byte_ff     <= req_source_byte;
         comp_cap_ff <= comp_cnt_ff;
         bpp_cap_ff  <= bpp_ff;
         last_cap_ff <= last_comp && last_col && last_row;
      end
      if (cmd.mul_en) begin
         prod_ff <= row_mul;
      end
      if (cmd.sum_en) begin
         sum_ff <= (AW'(col_q) + prod_ff) * AW'(bpp_cap_ff);
      end
   end

   // output register
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         rsp_addr_ff <= sum_ff + AW'(comp_cap_ff);
         rsp_byte_ff <= byte_ff;
         rsp_last_ff <= last_cap_ff;
      end
   end

   assign status.item_ok  = item_ok;
   assign status.div_done = col_done && row_done;
   assign status.out_free = out_free;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_dest_address = rsp_addr_ff;
   assign rsp_dest_byte    = rsp_byte_ff;
   assign rsp_frame_last   = rsp_last_ff;

endmodule
`default_nettype wire

// File: rtl/nearest_neighbor_pow2_downscaler_core.sv
// Nearest-neighbor image rescaler with power-of-two or explicit target size.
// Request channel: req_valid / req_stall / req_source_byte, one source component
// byte per request in raster order (component, then column, then row).
// Response channel: rsp_valid / rsp_stall carry one destination write per
// request: rsp_dest_address, rsp_dest_byte and rsp_frame_last on the final
// byte of the frame. A request with an invalid format, an empty source or an
// empty target gives no response.
// Configuration: csr_write_enable / csr_index / csr_write_data, to be written
// only while the block is idle; the block itself does not enforce this. The
// target size is latched at each frame start. Two bit-serial dividers form the
// column and row quotients. A new request is taken only once the previous one
// is in the output register; req_stall is high while a request is in work.
// A finished response waits in the output register while rsp_stall is high,
// and the next request is still taken; a further response waits until the
// register frees up. Reset is synchronous: counters, state and rsp_valid clear,
// pow2_mode goes to one, the other settings to zero; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module nearest_neighbor_pow2_downscaler_core #(
   parameter int DIM_BITS       = 16,
   parameter int MAX_COMPONENTS = 4
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_enable,
   input  wire logic [nnpds_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [nnpds_pkg::CFG_W-1:0]         csr_write_data,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [nnpds_pkg::BYTE_W-1:0]        req_source_byte,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [nnpds_pkg::ADDR_W-1:0]             rsp_dest_address,
   output logic [nnpds_pkg::BYTE_W-1:0]             rsp_dest_byte,
   output logic                                     rsp_frame_last
);

   nnpds_pkg::cmd_type    cmd;
   nnpds_pkg::status_type status;

   nnpds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   nnpds_dpath #(
      .DIM_BITS       (DIM_BITS),
      .MAX_COMPONENTS (MAX_COMPONENTS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_source_byte  (req_source_byte),
      .rsp_stall        (rsp_stall),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_dest_address (rsp_dest_address),
      .rsp_dest_byte    (rsp_dest_byte),
      .rsp_frame_last   (rsp_frame_last)
   );

endmodule
`default_nettype wire
